// File: sv/psched_pkg.sv
`timescale 1ns / 1ps

package psched_pkg;

   // slot table size and derived widths
   localparam int TASK_SLOTS = 8;
   localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

   localparam int REM_W      = 32;
   localparam int PER_W      = 16;
   localparam int ENTRY_W    = REM_W + PER_W;
   localparam int PORT_IDX_W = 3;

   localparam logic [REM_W-1:0] IDLE_NONE = 32'hFFFF_FFFF;

   // request codes
   localparam logic REQ_ADD      = 1'b0;
   localparam logic REQ_DISPATCH = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic add_wr;
      logic walk_start;
      logic walk_step;
      logic rsp_load;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic req_dispatch;
      logic last_slot;
   } dp_status_type;

   function automatic logic [REM_W-1:0] widen16(input logic [PER_W-1:0] v);
      return {{(REM_W - PER_W){v[PER_W-1]}}, v};
   endfunction

   function automatic logic [PORT_IDX_W-1:0] idx_to_port(input logic [IDX_W-1:0] idx);
      logic [IDX_W+PORT_IDX_W-1:0] wide;
      wide = {{PORT_IDX_W{1'b0}}, idx};
      return wide[PORT_IDX_W-1:0];
   endfunction

endpackage

// File: sv/psched_ram.sv
`timescale 1ns / 1ps

module psched_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/psched_ctrl.sv
`timescale 1ns / 1ps

module psched_ctrl
   import psched_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ADD  = 5'b00010,
      ST_RD   = 5'b00100,
      ST_WALK = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               state_in     = status.req_dispatch ? ST_RD : ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_wr = 1'b1;
            state_in   = ST_DONE;
         end
         ST_RD: begin
            cmd.walk_start = 1'b1;
            state_in       = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.last_slot) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result stage overwritten while full");

   a_walk_covers_all: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && !status.last_slot) |=> (state_ff == ST_WALK))
      else $error("slot walk ended early");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_ADD || state_ff == ST_RD))
      else $error("accepted request not started");
`endif

endmodule

// File: sv/psched_dp.sv
`timescale 1ns / 1ps

module psched_dp
   import psched_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_type,
   input  logic signed [15:0]     req_start_wait,
   input  logic signed [15:0]     req_task_period,
   input  logic [31:0]            req_elapsed_ticks,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   output logic                   rsp_granted,
   output logic [PORT_IDX_W-1:0]  rsp_task_index,
   output logic [REM_W-1:0]       rsp_idle_ticks
);

   // latched request
   logic                  req_type_ff;
   logic [PER_W-1:0]      start_wait_ff;
   logic [PER_W-1:0]      task_period_ff;
   logic [REM_W-1:0]      elapsed_ff;

   // slot bookkeeping
   logic [CNT_W-1:0]      slots_used_ff, slots_used_in;
   logic [TASK_SLOTS-1:0] running_ff, running_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;

   // running answer
   logic                  granted_ff, granted_in;
   logic [IDX_W-1:0]      index_ff, index_in;
   logic [REM_W-1:0]      idle_ff, idle_in;

   // result stage
   logic                  rsp_granted_ff;
   logic [IDX_W-1:0]      rsp_index_ff;
   logic [REM_W-1:0]      rsp_idle_ff;

   // slot memory: remaining time over period
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic [IDX_W-1:0]      rd_addr;
   logic [ENTRY_W-1:0]    rd_data;

   logic                  table_full;
   logic [REM_W-1:0]      rem_old;
   logic [PER_W-1:0]      per_old;
   logic [REM_W-1:0]      rem_new;
   logic [REM_W-1:0]      rem_reload;
   logic                  slot_ready;
   logic                  slot_run;
   logic                  pick;

   psched_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TASK_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign table_full = (slots_used_ff >= CNT_W'(TASK_SLOTS));

   assign rem_old    = rd_data[ENTRY_W-1:PER_W];
   assign per_old    = rd_data[PER_W-1:0];
   assign rem_new    = rem_old - elapsed_ff;
   assign rem_reload = rem_new + widen16(per_old);
   assign slot_ready = (rem_new == '0) || rem_new[REM_W-1];
   assign slot_run   = running_ff[cnt_ff];
   assign pick       = slot_run && slot_ready && !granted_ff;

   assign rd_addr = cmd.walk_start ? '0 : IDX_W'(cnt_ff + 1'b1);

   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = cnt_ff;
      wr_data       = {rem_new, per_old};
      slots_used_in = slots_used_ff;
      running_in    = running_ff;
      cnt_in        = cnt_ff;
      granted_in    = granted_ff;
      index_in      = index_ff;
      idle_in       = idle_ff;

      if (cmd.add_wr) begin
         granted_in = 1'b0;
         index_in   = '0;
         idle_in    = '0;
         if (!table_full) begin
            wr_en         = 1'b1;
            wr_addr       = slots_used_ff[IDX_W-1:0];
            wr_data       = {widen16(start_wait_ff), task_period_ff};
            running_in[slots_used_ff[IDX_W-1:0]] = 1'b1;
            slots_used_in = slots_used_ff + 1'b1;
            granted_in    = 1'b1;
            index_in      = slots_used_ff[IDX_W-1:0];
         end
      end

      if (cmd.walk_start) begin
         cnt_in     = '0;
         granted_in = 1'b0;
         index_in   = '0;
         idle_in    = IDLE_NONE;
      end

      if (cmd.walk_step) begin
         cnt_in = IDX_W'(cnt_ff + 1'b1);
         if (slot_run) begin
            wr_en = 1'b1;
            if (pick) begin
               wr_data    = {rem_reload, per_old};
               granted_in = 1'b1;
               index_in   = cnt_ff;
            end
            if (slot_ready) begin
               idle_in = '0;
            end else if (rem_new < idle_ff) begin
               idle_in = rem_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_used_ff <= '0;
         running_ff    <= '0;
      end else begin
         slots_used_ff <= slots_used_in;
         running_ff    <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_type_ff    <= req_type;
         start_wait_ff  <= req_start_wait;
         task_period_ff <= req_task_period;
         elapsed_ff     <= req_elapsed_ticks;
      end
      cnt_ff     <= cnt_in;
      granted_ff <= granted_in;
      index_ff   <= index_in;
      idle_ff    <= idle_in;
      if (cmd.rsp_load) begin
         rsp_granted_ff <= granted_ff;
         rsp_index_ff   <= index_ff;
         rsp_idle_ff    <= idle_ff;
      end
   end

   assign status.req_dispatch = (req_type == REQ_DISPATCH);
   assign status.last_slot    = (cnt_ff == IDX_W'(TASK_SLOTS - 1));

   assign rsp_granted    = rsp_granted_ff;
   assign rsp_task_index = idx_to_port(rsp_index_ff);
   assign rsp_idle_ticks = rsp_idle_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      slots_used_ff <= CNT_W'(TASK_SLOTS))
      else $error("slot count beyond table size");

   a_running_matches_used: assert property (@(posedge clock) disable iff (reset)
      $countones(running_ff) == int'(slots_used_ff))
      else $error("running flags disagree with slot count");

   a_grant_means_no_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && granted_ff && req_type_ff == REQ_DISPATCH) |=> (rsp_idle_ff == '0))
      else $error("selected slot but idle time not zero");
`endif

endmodule

// File: sv/periodic_task_scheduler.sv
`timescale 1ns / 1ps
// add: the request is latched, ST_ADD writes the new slot, then ST_DONE loads the result
// dispatch: the request is latched, ST_RD starts the walk, ST_WALK visits one slot a cycle
//   over the slot memory (one read and one write port), then ST_DONE loads the result
// the result is loaded once the result stage is free; the next request is taken back in ST_IDLE
// a waiting result does not stop the next request beat from being taken
// synchronous active-high reset clears the slot count, running flags and handshake state

module periodic_task_scheduler
   import psched_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic signed [15:0]    req_start_wait,
   input  logic signed [15:0]    req_task_period,
   input  logic [31:0]           req_elapsed_ticks,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_granted,
   output logic [PORT_IDX_W-1:0] rsp_task_index,
   output logic [REM_W-1:0]      rsp_idle_ticks
);

   // commands down, status up
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: request intake, add write, slot walk, result hand-off
   psched_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // slot memory, running flags, remaining-time arithmetic and result stage
   psched_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_start_wait    (req_start_wait),
      .req_task_period   (req_task_period),
      .req_elapsed_ticks (req_elapsed_ticks),
      .cmd               (cmd),
      .status            (status),
      .rsp_granted       (rsp_granted),
      .rsp_task_index    (rsp_task_index),
      .rsp_idle_ticks    (rsp_idle_ticks)
   );

endmodule
